### src/debounced_meter_pulse_counter_defines.svh
// Assertion macros used by the top-level RTL of the debounced meter pulse counter.
`ifndef DEBOUNCED_METER_PULSE_COUNTER_DEFINES_SVH
`define DEBOUNCED_METER_PULSE_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMPC_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error("dmpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMPC_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error("dmpc assertion failed");

`endif

### src/dmpc_pkg.sv
`default_nettype none

package dmpc_pkg;

    // Field and state widths.
    localparam int unsigned LEVEL_W   = 4;
    localparam int unsigned PARTIAL_W = 16;
    localparam int unsigned TOTAL_W   = 20;
    localparam int unsigned MODE_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Default parameter values.
    localparam int unsigned DEF_DEBOUNCE_LEVEL   = 8;
    localparam int unsigned DEF_WRAP_FIVE_DIGITS = 100000;
    localparam int unsigned DEF_WRAP_SIX_DIGITS  = 1000000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_MODE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_UNIT = CFG_IDX_W'(1);

    // Register reset values, and the digit mode code that selects the six-digit wrap.
    localparam logic [MODE_W-1:0]    MODE_RESET = MODE_W'(5);
    localparam logic [MODE_W-1:0]    MODE_SIX_DIGITS = MODE_W'(6);
    localparam logic [PARTIAL_W-1:0] PPU_RESET  = PARTIAL_W'(1000);

    // Action codes.
    localparam logic ACTION_POLL  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    // Counter state carried from one item to the next.
    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [PARTIAL_W-1:0] partial;
        logic [TOTAL_W-1:0]   total;
    } meter_state_t;

    // Per-item flags produced alongside the new state.
    typedef struct packed {
        logic counted;
        logic advanced;
        logic settling;
    } step_flags_t;

endpackage

`default_nettype wire

### src/dmpc_step.sv
`default_nettype none

// Next-state logic for one sample: integrator, prescaler and wrapped total.
module dmpc_step #(
    parameter int unsigned DEBOUNCE_LEVEL   = dmpc_pkg::DEF_DEBOUNCE_LEVEL,
    parameter int unsigned WRAP_FIVE_DIGITS = dmpc_pkg::DEF_WRAP_FIVE_DIGITS,
    parameter int unsigned WRAP_SIX_DIGITS  = dmpc_pkg::DEF_WRAP_SIX_DIGITS
) (
    input  wire logic                               action,
    input  wire logic                               pulse_level,
    input  wire logic [dmpc_pkg::MODE_W-1:0]        digit_mode,
    input  wire logic [dmpc_pkg::PARTIAL_W-1:0]     pulses_per_unit,
    input  wire dmpc_pkg::meter_state_t             state_cur,
    output dmpc_pkg::meter_state_t                  state_new,
    output dmpc_pkg::step_flags_t                   flags
);

    localparam int unsigned LW = dmpc_pkg::LEVEL_W;
    localparam int unsigned PW = dmpc_pkg::PARTIAL_W;
    localparam int unsigned TW = dmpc_pkg::TOTAL_W;

    localparam logic [LW-1:0] LEVEL_TOP    = LW'(DEBOUNCE_LEVEL);
    localparam logic [LW-1:0] LEVEL_BOTTOM = LW'(1);
    localparam logic [TW:0]   LIMIT_FIVE   = (TW+1)'(WRAP_FIVE_DIGITS);
    localparam logic [TW:0]   LIMIT_SIX    = (TW+1)'(WRAP_SIX_DIGITS);

    logic [LW-1:0] level_next;
    logic          counted;
    logic [PW-1:0] partial_inc;
    logic [TW:0]   total_inc;
    logic [TW:0]   limit;
    logic [TW:0]   total_wrapped;

    always_comb
    begin
        counted    = 1'b0;
        level_next = state_cur.level;
        if (pulse_level == 1'b0)
        begin
            if (state_cur.level != LEVEL_TOP)
            begin
                level_next = state_cur.level + LW'(1);
                counted    = (level_next == LEVEL_TOP);
            end
        end
        else if (state_cur.level != LEVEL_BOTTOM)
        begin
            level_next = state_cur.level - LW'(1);
        end
    end

    assign partial_inc   = state_cur.partial + PW'(1);
    assign total_inc     = {1'b0, state_cur.total} + (TW+1)'(1);
    assign limit         = (digit_mode == dmpc_pkg::MODE_SIX_DIGITS) ? LIMIT_SIX : LIMIT_FIVE;
    assign total_wrapped = (total_inc >= limit) ? (total_inc - limit) : total_inc;

    always_comb
    begin
        state_new      = state_cur;
        flags.counted  = 1'b0;
        flags.advanced = 1'b0;
        flags.settling = 1'b0;
        case (action)
            dmpc_pkg::ACTION_CLEAR:
            begin
                state_new.level   = LEVEL_BOTTOM;
                state_new.partial = '0;
            end
            default:
            begin
                state_new.level = level_next;
                flags.counted   = counted;
                flags.settling  = (level_next != LEVEL_BOTTOM) && (level_next != LEVEL_TOP);
                if (counted)
                begin
                    if (partial_inc == pulses_per_unit)
                    begin
                        state_new.partial = '0;
                        state_new.total   = total_wrapped[TW-1:0];
                        flags.advanced    = 1'b1;
                    end
                    else
                    begin
                        state_new.partial = partial_inc;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### src/debounced_meter_pulse_counter.sv
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------------
// sample   | sample_valid / sample_ready   | action, pulse_level
// result   | result_valid / result_ready   | total_units, partial_pulses, pulse_counted,
//          |                               | unit_advanced, settling
// config   | cfg_we (no wait)              | cfg_index, cfg_data
//
// Each accepted item produces exactly one result item on the next clock edge.
// One item per cycle is sustained while result_ready is high; the integrator, prescaler
// and total update in a single combinational step between state and result registers.
// sample_ready is low only while a result item is held and result_ready is low.
// Asynchronous active-low reset sets integrator to 1, counts to 0, digit_mode to 5,
// pulses_per_unit to 1000, and empties the result register.
`default_nettype none

`include "debounced_meter_pulse_counter_defines.svh"

module debounced_meter_pulse_counter #(
    parameter int unsigned DEBOUNCE_LEVEL   = dmpc_pkg::DEF_DEBOUNCE_LEVEL,
    parameter int unsigned WRAP_FIVE_DIGITS = dmpc_pkg::DEF_WRAP_FIVE_DIGITS,
    parameter int unsigned WRAP_SIX_DIGITS  = dmpc_pkg::DEF_WRAP_SIX_DIGITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_we,
    input  wire logic [dmpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dmpc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               sample_valid,
    output logic                                    sample_ready,
    input  wire logic                               action,
    input  wire logic                               pulse_level,

    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic [dmpc_pkg::TOTAL_W-1:0]            total_units,
    output logic [dmpc_pkg::PARTIAL_W-1:0]          partial_pulses,
    output logic                                    pulse_counted,
    output logic                                    unit_advanced,
    output logic                                    settling
);

    // Configuration registers.
    logic [dmpc_pkg::MODE_W-1:0]    digit_mode_reg;
    logic [dmpc_pkg::PARTIAL_W-1:0] ppu_reg;

    // Counter state; it always matches the most recently produced result item.
    dmpc_pkg::meter_state_t state_reg;
    dmpc_pkg::meter_state_t state_next;
    dmpc_pkg::step_flags_t  flags_next;

    // Result register.
    logic                   result_valid_reg;
    dmpc_pkg::step_flags_t  flags_reg;

    logic accept;

    // The result register frees up in the same cycle its item is taken, so a new
    // item can enter while the previous result leaves.
    assign sample_ready = !result_valid_reg || result_ready;
    assign accept       = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_mode_reg <= dmpc_pkg::MODE_RESET;
            ppu_reg        <= dmpc_pkg::PPU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmpc_pkg::REG_DIGIT_MODE:      digit_mode_reg <= cfg_data[dmpc_pkg::MODE_W-1:0];
                dmpc_pkg::REG_PULSES_PER_UNIT: ppu_reg        <= cfg_data;
                default:                       ;
            endcase
        end
    end

    dmpc_step #(
        .DEBOUNCE_LEVEL   (DEBOUNCE_LEVEL),
        .WRAP_FIVE_DIGITS (WRAP_FIVE_DIGITS),
        .WRAP_SIX_DIGITS  (WRAP_SIX_DIGITS)
    ) u_step (
        .action          (action),
        .pulse_level     (pulse_level),
        .digit_mode      (digit_mode_reg),
        .pulses_per_unit (ppu_reg),
        .state_cur       (state_reg),
        .state_new       (state_next),
        .flags           (flags_next)
    );

    // The state registers double as the count fields of the result item, since
    // a result always shows the state left by its own sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.level   <= dmpc_pkg::LEVEL_W'(1);
            state_reg.partial <= '0;
            state_reg.total   <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Flag payload needs no reset; it is qualified by result_valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign total_units    = state_reg.total;
    assign partial_pulses = state_reg.partial;
    assign pulse_counted  = flags_reg.counted;
    assign unit_advanced  = flags_reg.advanced;
    assign settling       = flags_reg.settling;

    // An advance always comes from a counted pulse and leaves the partial count empty.
    `DMPC_ASSERT_NOW(a_adv_clears_partial, clk, rst_n, result_valid && unit_advanced, partial_pulses == '0)
    `DMPC_ASSERT_NOW(a_adv_needs_pulse, clk, rst_n, result_valid && unit_advanced, pulse_counted)
    // A counted pulse puts the integrator at its top, so it cannot be settling.
    `DMPC_ASSERT_NOW(a_count_not_settling, clk, rst_n, result_valid && pulse_counted, !settling)
    // Every accepted item shows up as a result on the next edge.
    `DMPC_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, sample_valid && sample_ready, result_valid)

endmodule

`default_nettype wire

### bench/meter_reading_checker.sv
`default_nettype none

module meter_reading_checker
    import dmpc_pkg::*;
#(
    parameter int unsigned DEBOUNCE_LEVEL   = DEF_DEBOUNCE_LEVEL,
    parameter int unsigned WRAP_FIVE_DIGITS = DEF_WRAP_FIVE_DIGITS,
    parameter int unsigned WRAP_SIX_DIGITS  = DEF_WRAP_SIX_DIGITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  sample_valid,
    input  wire logic                  sample_ready,
    input  wire logic                  action,
    input  wire logic                  pulse_level,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire logic [TOTAL_W-1:0]    total_units,
    input  wire logic [PARTIAL_W-1:0]  partial_pulses,
    input  wire logic                  pulse_counted,
    input  wire logic                  unit_advanced,
    input  wire logic                  settling,
    output int                         mismatch_count,
    output int                         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 20;

    typedef struct packed {
        logic [TOTAL_W-1:0]   total;
        logic [PARTIAL_W-1:0] partial;
        step_flags_t          flags;
    } meter_reading_t;

    meter_state_t         meter;
    logic [MODE_W-1:0]    digit_mode;
    logic [PARTIAL_W-1:0] pulses_per_unit;
    meter_reading_t       expected_readings[$];
    meter_reading_t       want;
    meter_reading_t       seen;
    int                   errors = 0;
    bit                   match;

    // Applies one item to the meter state and returns the reading it must produce.
    function automatic meter_reading_t advance_meter(input logic act, input logic lvl);
        meter_reading_t     reading;
        logic [TOTAL_W:0]   bumped;
        logic [TOTAL_W:0]   wrap_at;
        reading = '0;
        if (act == ACTION_CLEAR)
        begin
            meter.level   = LEVEL_W'(1);
            meter.partial = '0;
        end
        else
        begin
            if (lvl == 1'b0)
            begin
                if (meter.level != LEVEL_W'(DEBOUNCE_LEVEL))
                begin
                    meter.level = meter.level + 1'b1;
                    reading.flags.counted = (meter.level == LEVEL_W'(DEBOUNCE_LEVEL));
                end
            end
            else if (meter.level != LEVEL_W'(1))
                meter.level = meter.level - 1'b1;

            if (reading.flags.counted)
            begin
                meter.partial = meter.partial + 1'b1;
                if (meter.partial == pulses_per_unit)
                begin
                    meter.partial = '0;
                    bumped  = {1'b0, meter.total} + 1'b1;
                    wrap_at = (digit_mode == MODE_SIX_DIGITS) ? (TOTAL_W+1)'(WRAP_SIX_DIGITS)
                                                              : (TOTAL_W+1)'(WRAP_FIVE_DIGITS);
                    // The wrap is one subtraction, even when the total sits above it.
                    if (bumped >= wrap_at)
                        bumped = bumped - wrap_at;
                    meter.total = bumped[TOTAL_W-1:0];
                    reading.flags.advanced = 1'b1;
                end
            end
        end
        reading.flags.settling = (meter.level != LEVEL_W'(1)) &&
                                 (meter.level != LEVEL_W'(DEBOUNCE_LEVEL));
        reading.total   = meter.total;
        reading.partial = meter.partial;
        return reading;
    endfunction

    function automatic bit field_ok(input string name, input int unsigned exp_val,
                                    input int unsigned got_val);
        if (exp_val != got_val && errors < REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
        return exp_val == got_val;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            meter.level     = LEVEL_W'(1);
            meter.partial   = '0;
            meter.total     = '0;
            digit_mode      = MODE_RESET;
            pulses_per_unit = PPU_RESET;
            expected_readings.delete();
        end
        else
        begin
            // Results leaving now belong to items accepted earlier, so compare first.
            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: reading total_units=%0d arrived with none expected",
                                 $time, total_units);
                    errors++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    seen.total          = total_units;
                    seen.partial        = partial_pulses;
                    seen.flags.counted  = pulse_counted;
                    seen.flags.advanced = unit_advanced;
                    seen.flags.settling = settling;
                    match = field_ok("total_units", want.total, seen.total)
                          & field_ok("partial_pulses", want.partial, seen.partial)
                          & field_ok("pulse_counted", want.flags.counted, seen.flags.counted)
                          & field_ok("unit_advanced", want.flags.advanced, seen.flags.advanced)
                          & field_ok("settling", want.flags.settling, seen.flags.settling);
                    if (!match)
                        errors++;
                end
            end

            if (sample_valid && sample_ready)
                expected_readings.push_back(advance_meter(action, pulse_level));

            if (cfg_we)
            begin
                if (cfg_index == REG_DIGIT_MODE)
                    digit_mode = cfg_data[MODE_W-1:0];
                else if (cfg_index == REG_PULSES_PER_UNIT)
                    pulses_per_unit = cfg_data[PARTIAL_W-1:0];
            end
        end
        mismatch_count <= errors;
        pending_count  <= expected_readings.size();
    end

endmodule

`default_nettype wire

### bench/debounced_meter_pulse_counter_tb.sv
`default_nettype none

module debounced_meter_pulse_counter_tb;
    import dmpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes that decode to no register; writes there must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(3);

    // Percentages of cycles in which a side holds back.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 53;
    localparam int IDLE_LIGHT = 20;

    // Random items per idling phase, and cycles without any handshake before giving up.
    localparam int PHASE_ITEMS    = 470;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_ready;
    logic                  action;
    logic                  pulse_level;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [TOTAL_W-1:0]    total_units;
    logic [PARTIAL_W-1:0]  partial_pulses;
    logic                  pulse_counted;
    logic                  unit_advanced;
    logic                  settling;

    int                    mismatch_count;
    int                    pending_count;

    int                    send_idle_pct  = IDLE_NONE;
    int                    recv_stall_pct = IDLE_NONE;
    int                    quiet_cycles   = 0;

    always #10 clk = ~clk;

    debounced_meter_pulse_counter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .action         (action),
        .pulse_level    (pulse_level),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .total_units    (total_units),
        .partial_pulses (partial_pulses),
        .pulse_counted  (pulse_counted),
        .unit_advanced  (unit_advanced),
        .settling       (settling)
    );

    // The checker tracks the meter on its own and compares every reading that leaves.
    meter_reading_checker reading_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .action         (action),
        .pulse_level    (pulse_level),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .total_units    (total_units),
        .partial_pulses (partial_pulses),
        .pulse_counted  (pulse_counted),
        .unit_advanced  (unit_advanced),
        .settling       (settling),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // The reading side stalls at random, one fresh decision per cycle.
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    // A healthy run keeps moving items on one of the two channels.
    // A long silence means the block has hung, so the run is stopped as a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("** debounced_meter_pulse_counter: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one sample item, after a random idle gap, and returns once it is taken.
    // Valid stays high from one item to the next, so it is only lowered while idling.
    task automatic send_item(input logic act, input logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        action       <= act;
        pulse_level  <= lvl;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    // Stops offering items and waits until every reading already owed has come out.
    // Each item yields exactly one reading, so nothing is still at work afterwards.
    task automatic quiesce();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Produces the given number of debounced pulses as fast as the line allows.
    // From the bottom, a clear and a run of low samples lift the integrator to the top;
    // after that, each high-low pair drops it by one and lifts it back, counting a pulse.
    task automatic pulse_train(input int pulses, input bit from_bottom);
        int left;
        left = pulses;
        if (from_bottom && left > 0)
        begin
            send_item(ACTION_CLEAR, 1'b1);
            repeat (DEF_DEBOUNCE_LEVEL - 1)
                send_item(ACTION_POLL, 1'b0);
            left--;
        end
        repeat (left)
        begin
            send_item(ACTION_POLL, 1'b1);
            send_item(ACTION_POLL, 1'b0);
        end
    endtask

    // Random line activity: mostly runs of one level, one to ten samples long, which can
    // settle the integrator or complete a pulse, with some single-sample chatter and an
    // occasional clear. Halfway through, the sender holds off until the block drains.
    task automatic random_traffic(input int count);
        int   sent;
        int   pick;
        int   run_len;
        logic lvl;
        bit   drained;
        sent    = 0;
        drained = 1'b0;
        while (sent < count)
        begin
            if (!drained && sent >= count / 2)
            begin
                quiesce();
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                send_item(ACTION_CLEAR, 1'($urandom));
                sent++;
            end
            else if (pick < 85)
            begin
                lvl     = 1'($urandom);
                run_len = $urandom_range(1, 10);
                repeat (run_len)
                    send_item(ACTION_POLL, lvl);
                sent += run_len;
            end
            else
            begin
                send_item(ACTION_POLL, 1'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_DIGIT_MODE;
        cfg_data     = '0;
        sample_valid = 1'b0;
        action       = ACTION_POLL;
        pulse_level  = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings. A clear ignores the line level,
        // a high sample at the bottom holds the integrator, low samples walk it up
        // through the settling range until the top counts a pulse, and a low sample
        // at the top counts nothing more.
        send_item(ACTION_CLEAR, 1'b0);
        send_item(ACTION_POLL, 1'b1);
        repeat (DEF_DEBOUNCE_LEVEL - 1)
            send_item(ACTION_POLL, 1'b0);
        send_item(ACTION_POLL, 1'b0);
        send_item(ACTION_POLL, 1'b1);
        send_item(ACTION_POLL, 1'b0);
        send_item(ACTION_CLEAR, 1'b1);

        // With a divisor of one, every counted pulse advances the total.
        write_reg(REG_PULSES_PER_UNIT, CFG_DATA_W'(1));
        pulse_train(2, 1'b1);
        send_item(ACTION_POLL, 1'b1);
        send_item(ACTION_CLEAR, 1'b0);

        // A few advances in six-digit mode, then back in five-digit mode.
        write_reg(REG_DIGIT_MODE, CFG_DATA_W'(MODE_SIX_DIGITS));
        pulse_train(3, 1'b1);
        write_reg(REG_DIGIT_MODE, CFG_DATA_W'(MODE_RESET));
        pulse_train(1, 1'b1);

        // A zero divisor set while the partial count is already above it: the partial
        // count keeps climbing without advancing the total.
        write_reg(REG_PULSES_PER_UNIT, CFG_DATA_W'(PPU_RESET));
        pulse_train(3, 1'b1);
        write_reg(REG_PULSES_PER_UNIT, CFG_DATA_W'(0));
        pulse_train(5, 1'b0);

        // Random phases, each under its own settings and idling pattern.
        write_reg(REG_DIGIT_MODE, CFG_DATA_W'(MODE_SIX_DIGITS));
        write_reg(REG_PULSES_PER_UNIT, CFG_DATA_W'(1));
        random_traffic(PHASE_ITEMS);

        write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
        write_reg(REG_DIGIT_MODE, CFG_DATA_W'(0));
        write_reg(REG_PULSES_PER_UNIT, CFG_DATA_W'(3));
        send_idle_pct = IDLE_HEAVY;
        random_traffic(PHASE_ITEMS);

        write_reg(REG_UNUSED_HI, '1);
        write_reg(REG_DIGIT_MODE, CFG_DATA_W'(15));
        write_reg(REG_PULSES_PER_UNIT, '1);
        send_idle_pct  = IDLE_NONE;
        recv_stall_pct = IDLE_HEAVY;
        random_traffic(PHASE_ITEMS);

        // Only the low bits of the data reach the digit mode; the rest must be dropped.
        write_reg(REG_DIGIT_MODE, {{(CFG_DATA_W-MODE_W){1'b1}}, MODE_SIX_DIGITS});
        write_reg(REG_PULSES_PER_UNIT, CFG_DATA_W'($urandom_range(1, 5)));
        send_idle_pct  = IDLE_LIGHT;
        recv_stall_pct = IDLE_LIGHT;
        random_traffic(PHASE_ITEMS);

        // Drain, then keep the clock running so that any stray reading can show up.
        quiesce();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("** debounced_meter_pulse_counter: PASSED **");
        else
            $display("** debounced_meter_pulse_counter: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
